/* design/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first free slot allocator: field widths,
// command codes, controller states and the controller-to-datapath commands.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    // width of every 6-bit payload field and of the configuration register
    localparam int FIELD_W = 6;

    // slots counted per group in the free-count adder tree
    localparam int GRP_W   = 8;
    localparam int GCNT_W  = $clog2(GRP_W + 1);

    // reset value of the slot count register
    localparam logic [FIELD_W-1:0] SLOTS_RESET = FIELD_W'(32);

    // command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SUM
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // apply the accepted command to the occupancy map
        logic count;    // register per-group free counts
        logic sum;      // add group counts and load the result register
    } t_dp_cmd;

    // number of ones in one group of slots
    function automatic logic [GCNT_W-1:0] grp_popcount(input logic [GRP_W-1:0] bits);
        logic [GCNT_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < GRP_W; k++) begin
            acc = acc + GCNT_W'(bits[k]);
        end
        return acc;
    endfunction

endpackage

/* design/ffsa_ifs.sv */
// ----------------------------------------------------------------------------
// ffsa_ifs
// Valid/ready channels of the allocator: command channel and result channel.
// ----------------------------------------------------------------------------
interface ffsa_cmd_if;
    import ffsa_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [FIELD_W-1:0] slot_number;

    modport source (output valid, output command, output slot_number, input ready);
    modport sink   (input valid, input command, input slot_number, output ready);
endinterface

interface ffsa_res_if;
    import ffsa_pkg::*;

    logic               valid;
    logic               ready;
    logic               success;
    logic [FIELD_W-1:0] granted_slot;
    logic [FIELD_W-1:0] free_count;

    modport source (output valid, output success, output granted_slot,
                    output free_count, input ready);
    modport sink   (input valid, input success, input granted_slot,
                    input free_count, output ready);
endinterface

/* design/ffsa_ctrl.sv */
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: accepts a command, steps the datapath through
// map update, group count and sum, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ffsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ffsa_pkg::t_dp_cmd o_cmd
);
    import ffsa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // state and result flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_COUNT;
                end
            end
            ST_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = ST_SUM;
            end
            ST_SUM: begin
                // result register must be empty or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.sum = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result valid: set by the sum step, cleared by an output transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.sum) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

    // accepted command always moves on to the count step
    a_load_to_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_COUNT))
        else $error("accepted command did not enter count step");

    // count step always moves on to the sum step in the next cycle
    a_count_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COUNT) |=> (r_state == ST_SUM))
        else $error("count step did not advance to sum");

    // an empty result register never stalls the sum step
    a_sum_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("sum step stalled with empty result register");

endmodule

/* design/ffsa_datapath.sv */
// ----------------------------------------------------------------------------
// ffsa_datapath
// Occupancy map, slot count register, first-free search, release check and
// the two-step free-slot counter feeding the result register.
// ----------------------------------------------------------------------------
module ffsa_datapath #(
    parameter int MAX_SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffsa_pkg::t_dp_cmd             i_cmd,
    input  logic                          i_cfg_we,
    input  logic [ffsa_pkg::FIELD_W-1:0]  i_cfg_wdata,
    input  logic                          i_command,
    input  logic [ffsa_pkg::FIELD_W-1:0]  i_slot_number,
    output logic                          o_success,
    output logic [ffsa_pkg::FIELD_W-1:0]  o_granted_slot,
    output logic [ffsa_pkg::FIELD_W-1:0]  o_free_count
);
    import ffsa_pkg::*;

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int NGRP  = (MAX_SLOTS + GRP_W - 1) / GRP_W;
    localparam int PAD_W = NGRP * GRP_W;
    localparam int SUM_W = $clog2(PAD_W + 1);

    logic [FIELD_W-1:0]   r_slots_cfg;
    logic [MAX_SLOTS-1:0] r_map;
    logic [MAX_SLOTS-1:0] n_map;
    logic [GCNT_W-1:0]    r_grp_cnt [NGRP];
    logic                 r_success;
    logic                 n_success;
    logic [FIELD_W-1:0]   r_granted;
    logic [FIELD_W-1:0]   n_granted;
    logic                 r_out_success;
    logic [FIELD_W-1:0]   r_out_granted;
    logic [FIELD_W-1:0]   r_free;

    logic [CNT_W-1:0]     w_n;
    logic [MAX_SLOTS-1:0] w_mask;
    logic [MAX_SLOTS-1:0] w_cand;
    logic [MAX_SLOTS-1:0] w_alloc_hot;
    logic [MAX_SLOTS-1:0] w_rel_hot;
    logic [FIELD_W-1:0]   w_gnt_num;
    logic [PAD_W-1:0]     w_free_pad;
    logic [SUM_W-1:0]     w_sum;

    // managed slot count, saturated to capacity, and its mask
    always_comb begin
        if (int'(r_slots_cfg) > MAX_SLOTS) begin
            w_n = CNT_W'(MAX_SLOTS);
        end else begin
            w_n = CNT_W'(r_slots_cfg);
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w_mask[i] = (int'(w_n) > i);
        end
    end

    // first free slot: isolate lowest candidate bit and encode its number
    assign w_cand      = ~r_map & w_mask;
    assign w_alloc_hot = w_cand & (~w_cand + MAX_SLOTS'(1));

    always_comb begin
        w_gnt_num = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_gnt_num = FIELD_W'(i + 1);
            end
        end
    end

    // release target decode, limited to managed slots
    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w_rel_hot[i] = (int'(i_slot_number) == i + 1) && w_mask[i];
        end
    end

    // map update and flags for the accepted command
    always_comb begin
        n_map     = r_map;
        n_success = r_success;
        n_granted = r_granted;
        if (i_cmd.load) begin
            if (i_command == CMD_ALLOC) begin
                n_map     = r_map | w_alloc_hot;
                n_success = |w_cand;
                n_granted = w_gnt_num;
            end else begin
                n_map     = r_map & ~(w_rel_hot & r_map);
                n_success = |(w_rel_hot & r_map);
                n_granted = '0;
            end
        end
    end

    // configuration and occupancy registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_cfg <= SLOTS_RESET;
            r_map       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_slots_cfg <= i_cfg_wdata;
            end
            r_map <= n_map;
        end
    end

    // free bits padded to whole groups
    assign w_free_pad = PAD_W'(~r_map & w_mask);

    // group counts, then sum of groups
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_sum = w_sum + SUM_W'(r_grp_cnt[g]);
        end
    end

    // payload registers; flags are staged until the sum step loads the result
    always_ff @(posedge i_clk) begin
        r_success <= n_success;
        r_granted <= n_granted;
        if (i_cmd.count) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp_cnt[g] <= grp_popcount(w_free_pad[g*GRP_W +: GRP_W]);
            end
        end
        if (i_cmd.sum) begin
            r_free        <= FIELD_W'(w_sum);
            r_out_success <= r_success;
            r_out_granted <= r_granted;
        end
    end

    assign o_success      = r_out_success;
    assign o_granted_slot = r_out_granted;
    assign o_free_count   = r_free;

    // one command touches at most one slot
    a_one_slot_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> ($countones(r_map ^ $past(r_map)) <= 1))
        else $error("more than one occupancy bit changed");

    // success always matches an actual map change
    a_success_changes_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_success == (r_map != $past(r_map))))
        else $error("success flag disagrees with map update");

    // free count never exceeds the managed slot count
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sum |=> (int'(r_free) <= int'($past(w_n))))
        else $error("free count above managed slot count");

endmodule

/* design/first_free_slot_allocator_top.sv */
// Sequence: a command is taken only in the idle state and updates the map at the
//   transfer edge; its result is registered by the group count and group sum steps.
// Commands: a new one is not taken until the update/count/sum sequence is done;
//   a stalled result holds the next command in the sum step until it is taken.
// Reset: synchronous active low; all slots free, slot count 32, no result pending.
// ----------------------------------------------------------------------------
// first_free_slot_allocator_top
// Bitmap first-fit slot allocator: grants the lowest free slot, releases a
// given slot and reports the free-slot count with every result.
// ----------------------------------------------------------------------------
module first_free_slot_allocator_top #(
    parameter int MAX_SLOTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ffsa_cmd_if.sink                     i_cmd_ch,
    ffsa_res_if.source                   o_res_ch,
    input  logic                         i_cfg_we,
    input  logic [ffsa_pkg::FIELD_W-1:0] i_cfg_wdata
);
    import ffsa_pkg::*;

    t_dp_cmd w_cmd;

    // sequencer
    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (i_cmd_ch.ready),
        .o_out_valid (o_res_ch.valid),
        .i_out_ready (o_res_ch.ready),
        .o_cmd       (w_cmd)
    );

    // occupancy map and counters
    ffsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_cmd_ch.command),
        .i_slot_number  (i_cmd_ch.slot_number),
        .o_success      (o_res_ch.success),
        .o_granted_slot (o_res_ch.granted_slot),
        .o_free_count   (o_res_ch.free_count)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first free slot allocator. A directed table with
// register writes between rows walks the edge cases, then random phases at
// several slot counts mix allocate/release traffic. Each reply is checked against
// the row's own reply where a directed row gives one, else against a shadow copy
// of the occupancy map, with bursty commands and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import ffsa_pkg::*;

    localparam int MAX_SLOTS  = 32;
    localparam int CLK_HALF   = 4;
    localparam int NUM_PHASES = 9;

    typedef struct packed {
        logic               success;
        logic [FIELD_W-1:0] granted_slot;
        logic [FIELD_W-1:0] free_count;
    } t_slot_reply;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               command;
        logic [FIELD_W-1:0] value;      // slot number, or slot count for a write
        logic               typed;      // reply given in the row
        t_slot_reply        reply;
    } t_dir_row;

    localparam int NUM_ROWS = 23;

    // directed rows: edge cases of release, full map, count of zero and saturation
    t_dir_row dir_rows [NUM_ROWS] = '{
        '{ROW_ITEM, CMD_RELEASE, 6'd0,  1'b1, '{1'b0, 6'd0, 6'd32}},
        '{ROW_ITEM, CMD_ALLOC,   6'd0,  1'b1, '{1'b1, 6'd1, 6'd31}},
        '{ROW_ITEM, CMD_ALLOC,   6'd63, 1'b1, '{1'b1, 6'd2, 6'd30}},
        '{ROW_ITEM, CMD_RELEASE, 6'd1,  1'b1, '{1'b1, 6'd0, 6'd31}},
        '{ROW_ITEM, CMD_RELEASE, 6'd1,  1'b1, '{1'b0, 6'd0, 6'd31}},
        '{ROW_ITEM, CMD_RELEASE, 6'd33, 1'b1, '{1'b0, 6'd0, 6'd31}},
        '{ROW_ITEM, CMD_RELEASE, 6'd63, 1'b1, '{1'b0, 6'd0, 6'd31}},
        '{ROW_ITEM, CMD_ALLOC,   6'd0,  1'b1, '{1'b1, 6'd1, 6'd30}},
        '{ROW_CFG,  CMD_ALLOC,   6'd3,  1'b0, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_ALLOC,   6'd42, 1'b1, '{1'b1, 6'd3, 6'd0}},
        '{ROW_ITEM, CMD_ALLOC,   6'd0,  1'b1, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_RELEASE, 6'd4,  1'b1, '{1'b0, 6'd0, 6'd0}},
        '{ROW_CFG,  CMD_ALLOC,   6'd1,  1'b0, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_RELEASE, 6'd2,  1'b1, '{1'b0, 6'd0, 6'd0}},
        '{ROW_CFG,  CMD_ALLOC,   6'd0,  1'b0, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_ALLOC,   6'd0,  1'b1, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_RELEASE, 6'd1,  1'b1, '{1'b0, 6'd0, 6'd0}},
        '{ROW_CFG,  CMD_ALLOC,   6'd63, 1'b0, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_RELEASE, 6'd3,  1'b1, '{1'b1, 6'd0, 6'd30}},
        '{ROW_ITEM, CMD_ALLOC,   6'd21, 1'b1, '{1'b1, 6'd3, 6'd29}},
        '{ROW_ITEM, CMD_RELEASE, 6'd32, 1'b1, '{1'b0, 6'd0, 6'd29}},
        '{ROW_CFG,  CMD_ALLOC,   6'd32, 1'b0, '{1'b0, 6'd0, 6'd0}},
        '{ROW_ITEM, CMD_ALLOC,   6'd0,  1'b0, '{1'b0, 6'd0, 6'd0}}
    };

    // slot counts of the random phases, the last one drawn at run time
    logic [FIELD_W-1:0] phase_limits [NUM_PHASES] = '{6'd32, 6'd7, 6'd1, 6'd63, 6'd0,
                                                      6'd20, 6'd2, 6'd32, 6'd0};

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [FIELD_W-1:0] cfg_wdata;

    ffsa_cmd_if cmd_ch ();
    ffsa_res_if res_ch ();

    // shadow state of the allocator
    logic [MAX_SLOTS-1:0] occ_bits;
    logic [FIELD_W-1:0]   slot_limit;

    t_slot_reply pending_replies [$];
    int          err_cnt;
    int          burst_left;
    bit          idle_enable;

    first_free_slot_allocator_top #(
        .MAX_SLOTS  (MAX_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_ch   (cmd_ch),
        .o_res_ch   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // apply one command to the shadow map and return the reply it gives
    function automatic t_slot_reply apply_slot_cmd(input logic cmd,
                                                   input logic [FIELD_W-1:0] slot);
        int          n;
        bit          found;
        t_slot_reply r;
        n = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : int'(slot_limit);
        found = 1'b0;
        r = '0;
        if (cmd == CMD_ALLOC) begin
            for (int i = 0; i < n; i++) begin
                if (!found && !occ_bits[i]) begin
                    occ_bits[i]    = 1'b1;
                    found          = 1'b1;
                    r.success      = 1'b1;
                    r.granted_slot = FIELD_W'(i + 1);
                end
            end
        end else if (slot >= 1 && int'(slot) <= n) begin
            if (occ_bits[slot - 1]) begin
                occ_bits[slot - 1] = 1'b0;
                r.success          = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (!occ_bits[i]) r.free_count = r.free_count + 1'b1;
        end
        return r;
    endfunction

    // pick a slot that is taken among the managed ones, or a random number
    function automatic logic [FIELD_W-1:0] pick_taken_slot();
        int n;
        int taken [$];
        n = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : int'(slot_limit);
        for (int i = 0; i < n; i++) begin
            if (occ_bits[i]) taken.push_back(i + 1);
        end
        if (taken.size() == 0) return FIELD_W'($urandom_range(0, 63));
        return FIELD_W'(taken[$urandom_range(0, taken.size() - 1)]);
    endfunction

    // one command transfer, then an idle gap when the burst runs out
    task automatic send_cmd(input logic cmd, input logic [FIELD_W-1:0] slot,
                            input logic typed, input t_slot_reply typed_reply);
        t_slot_reply r;
        @(negedge i_clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.slot_number <= slot;
        do @(posedge i_clk); while (!cmd_ch.ready);
        r = apply_slot_cmd(cmd, slot);
        pending_replies.push_back(typed ? typed_reply : r);
        if (idle_enable) begin
            burst_left--;
            if (burst_left <= 0) begin
                @(negedge i_clk);
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // stop sending and wait for every reply, plus the block's pipeline depth
    task automatic wait_all_replies();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // slot count write, only with the block idle
    task automatic write_slot_limit(input logic [FIELD_W-1:0] val);
        wait_all_replies();
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        slot_limit = val;
    endtask

    // receiver back-pressure, pattern redrawn at random from four modes at random intervals
    initial begin
        int mode;
        int left;
        int cyc;
        res_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        cyc  = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 80);
            end
            left--;
            case (mode)
                0: begin
                    res_ch.ready <= 1'b1;
                end
                1: begin
                    res_ch.ready <= ($urandom_range(0, 99) < 75);
                end
                2: begin
                    res_ch.ready <= ($urandom_range(0, 99) < 25);
                end
                default: begin
                    res_ch.ready <= (cyc % 5 == 0);
                end
            endcase
        end
    end

    // reply check on every result transfer
    always @(posedge i_clk) begin : reply_check
        t_slot_reply want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_replies.size() == 0) begin
                $error("reply with no command pending");
                err_cnt++;
            end else begin
                want = pending_replies.pop_front();
                if (res_ch.success !== want.success) begin
                    $error("success: expected %0d, got %0d", want.success, res_ch.success);
                    err_cnt++;
                end
                if (res_ch.granted_slot !== want.granted_slot) begin
                    $error("granted_slot: expected %0d, got %0d",
                           want.granted_slot, res_ch.granted_slot);
                    err_cnt++;
                end
                if (res_ch.free_count !== want.free_count) begin
                    $error("free_count: expected %0d, got %0d",
                           want.free_count, res_ch.free_count);
                    err_cnt++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int                 alloc_pct;
        int                 n_items;
        logic               cmd;
        logic [FIELD_W-1:0] slot;
        i_rst_n            = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_ALLOC;
        cmd_ch.slot_number = '0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        err_cnt            = 0;
        occ_bits           = '0;
        slot_limit         = SLOTS_RESET;
        idle_enable        = 1'b1;
        burst_left         = $urandom_range(1, 12);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                write_slot_limit(dir_rows[k].value);
            end else begin
                send_cmd(dir_rows[k].command, dir_rows[k].value,
                         dir_rows[k].typed, dir_rows[k].reply);
            end
        end

        // random phases, each at its own slot count
        phase_limits[NUM_PHASES-1] = FIELD_W'($urandom_range(0, 63));
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_slot_limit(phase_limits[p]);
            idle_enable = (p % 3 != 2);
            alloc_pct   = $urandom_range(55, 85);
            n_items     = $urandom_range(70, 95);
            for (int k = 0; k < n_items; k++) begin
                // swing from filling to draining halfway through the phase
                if (k == n_items / 2) alloc_pct = 100 - alloc_pct;
                if ($urandom_range(0, 99) < alloc_pct) begin
                    cmd  = CMD_ALLOC;
                    slot = FIELD_W'($urandom_range(0, 63));
                end else begin
                    cmd  = CMD_RELEASE;
                    slot = ($urandom_range(0, 99) < 70) ? pick_taken_slot()
                                                        : FIELD_W'($urandom_range(0, 63));
                end
                send_cmd(cmd, slot, 1'b0, '0);
                if ($urandom_range(0, 59) == 0) wait_all_replies();
            end
        end

        // drain and report
        wait_all_replies();
        repeat (16) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d replies never arrived", pending_replies.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* first_free_slot_allocator_top.f */
design/ffsa_pkg.sv
design/ffsa_ifs.sv
design/ffsa_ctrl.sv
design/ffsa_datapath.sv
design/first_free_slot_allocator_top.sv
tb/tb_top.sv
